// ----- rtl/fbb_pkg.sv -----
// ----------------------------------------------------------------------------
// fbb_pkg: shared constants and types for the foreground bounding box
// Register map codes, configuration field widths and reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package fbb_pkg;

  // Default geometry of the datapath
  localparam int COORD_BITS_DEF  = 10;
  localparam int SAMPLE_BITS_DEF = 16;

  // Configuration field widths
  localparam int CFG_SIZE_W = 11;
  localparam int CFG_PAD_W  = 4;
  localparam int CFG_THR_W  = 15;
  localparam int CFG_DATA_W = 15;
  localparam int CFG_IDX_W  = 3;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SIZE_X  = 3'd0,
    REG_SIZE_Y  = 3'd1,
    REG_SIZE_Z  = 3'd2,
    REG_PAD     = 3'd3,
    REG_THRESH  = 3'd4
  } cfg_reg_e;

  // Reset values
  localparam logic [CFG_SIZE_W-1:0] SIZE_RST   = 11'd1024;
  localparam logic [CFG_PAD_W-1:0]  PAD_RST    = 4'd2;
  localparam logic [CFG_THR_W-1:0]  THRESH_RST = 15'd0;

  // Axis numbering inside coordinate arrays
  localparam int AXIS_X = 0;
  localparam int AXIS_Y = 1;
  localparam int AXIS_Z = 2;
  localparam int NUM_AXES = 3;

endpackage : fbb_pkg

`default_nettype wire

// ----- rtl/fbb_if.sv -----
// ----------------------------------------------------------------------------
// fbb_if: valid/ready channels of the foreground bounding box
// Sample channel (one voxel per item) and result channel (one box per item).
// ----------------------------------------------------------------------------
`default_nettype none

interface fbb_smp_if #(
  parameter int SAMPLE_BITS = fbb_pkg::SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface : fbb_smp_if

interface fbb_res_if #(
  parameter int COORD_BITS = fbb_pkg::COORD_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic                  found;
  logic [COORD_BITS-1:0] box_min_x;
  logic [COORD_BITS-1:0] box_max_x;
  logic [COORD_BITS-1:0] box_min_y;
  logic [COORD_BITS-1:0] box_max_y;
  logic [COORD_BITS-1:0] box_min_z;
  logic [COORD_BITS-1:0] box_max_z;

  modport source (output valid, output found, output box_min_x, output box_max_x,
                  output box_min_y, output box_max_y, output box_min_z,
                  output box_max_z, input ready);
  modport sink   (input valid, input found, input box_min_x, input box_max_x,
                  input box_min_y, input box_max_y, input box_min_z,
                  input box_max_z, output ready);
endinterface : fbb_res_if

`default_nettype wire

// ----- rtl/fbb_front.sv -----
// ----------------------------------------------------------------------------
// fbb_front: voxel classifier and raster position counters
// Tag each accepted voxel with its position, foreground flag and end flag.
// ----------------------------------------------------------------------------
`default_nettype none

module fbb_front #(
  parameter int COORD_BITS  = fbb_pkg::COORD_BITS_DEF,
  parameter int SAMPLE_BITS = fbb_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                                         clk_i,
  input  wire logic                                         rst_ni,
  input  wire logic                                         valid_i,
  input  wire logic signed [SAMPLE_BITS-1:0]                sample_i,
  output      logic                                         ready_o,
  input  wire logic [fbb_pkg::CFG_THR_W-1:0]                thresh_i,
  input  wire logic [fbb_pkg::NUM_AXES-1:0][COORD_BITS-1:0] last_i,
  input  wire logic                                         q_full_i,
  output      logic                                         push_o,
  output      logic [fbb_pkg::NUM_AXES-1:0][COORD_BITS-1:0] pos_o,
  output      logic                                         fg_o,
  output      logic                                         last_o
);

  localparam int MW = (SAMPLE_BITS > fbb_pkg::CFG_THR_W) ? SAMPLE_BITS
                                                         : fbb_pkg::CFG_THR_W;

  logic [fbb_pkg::NUM_AXES-1:0][COORD_BITS-1:0] pos_q, pos_d;
  logic [fbb_pkg::NUM_AXES-1:0]                 at_end;
  logic [SAMPLE_BITS-1:0]                       mag;
  logic [SAMPLE_BITS-1:0]                       raw;

  // The most negative sample negates onto itself, which is its exact magnitude
  assign raw = sample_i;
  assign mag = raw[SAMPLE_BITS-1] ? (~raw + SAMPLE_BITS'(1)) : raw;

  assign ready_o = !q_full_i;
  assign push_o  = valid_i && !q_full_i;

  always_comb begin
    for (int a = 0; a < fbb_pkg::NUM_AXES; a++) begin
      at_end[a] = pos_q[a] >= last_i[a];
    end
  end

  assign pos_o  = pos_q;
  assign fg_o   = MW'(mag) > MW'(thresh_i);
  assign last_o = &at_end;

  always_comb begin
    pos_d = pos_q;
    if (push_o) begin
      if (&at_end) begin
        pos_d = '0;
      end else if (!at_end[fbb_pkg::AXIS_X]) begin
        pos_d[fbb_pkg::AXIS_X] = pos_q[fbb_pkg::AXIS_X] + COORD_BITS'(1);
      end else begin
        pos_d[fbb_pkg::AXIS_X] = '0;
        if (!at_end[fbb_pkg::AXIS_Y]) begin
          pos_d[fbb_pkg::AXIS_Y] = pos_q[fbb_pkg::AXIS_Y] + COORD_BITS'(1);
        end else begin
          pos_d[fbb_pkg::AXIS_Y] = '0;
          pos_d[fbb_pkg::AXIS_Z] = pos_q[fbb_pkg::AXIS_Z] + COORD_BITS'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else begin
      pos_q <= pos_d;
    end
  end

endmodule : fbb_front

`default_nettype wire

// ----- rtl/fbb_fifo.sv -----
// ----------------------------------------------------------------------------
// fbb_fifo: short register queue between front and back
// Hold tagged voxels so that either side can stall on its own.
// ----------------------------------------------------------------------------
`default_nettype none

module fbb_fifo #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  output      logic             full_o,
  input  wire logic             pop_i,
  output      logic [WIDTH-1:0] rdata_o,
  output      logic             valid_o
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [CW-1:0]    cnt_q;

  assign full_o  = cnt_q == CW'(DEPTH);
  assign valid_o = cnt_q != '0;
  assign rdata_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CW'(1);
      end
    end
  end

endmodule : fbb_fifo

`default_nettype wire

// ----- rtl/fbb_back.sv -----
// ----------------------------------------------------------------------------
// fbb_back: box tracker and result register
// Fold foreground positions into min/max registers; emit the padded box.
// ----------------------------------------------------------------------------
`default_nettype none

module fbb_back #(
  parameter int COORD_BITS = fbb_pkg::COORD_BITS_DEF
) (
  input  wire logic                                         clk_i,
  input  wire logic                                         rst_ni,
  input  wire logic                                         q_valid_i,
  input  wire logic [fbb_pkg::NUM_AXES-1:0][COORD_BITS-1:0] pos_i,
  input  wire logic                                         fg_i,
  input  wire logic                                         last_i,
  output      logic                                         pop_o,
  input  wire logic [fbb_pkg::CFG_PAD_W-1:0]                pad_i,
  input  wire logic [fbb_pkg::NUM_AXES-1:0][COORD_BITS-1:0] axis_last_i,
  output      logic                                         out_valid_o,
  input  wire logic                                         out_ready_i,
  output      logic                                         found_o,
  output      logic [fbb_pkg::NUM_AXES-1:0][COORD_BITS-1:0] box_min_o,
  output      logic [fbb_pkg::NUM_AXES-1:0][COORD_BITS-1:0] box_max_o
);

  localparam int NA = fbb_pkg::NUM_AXES;

  logic [NA-1:0][COORD_BITS-1:0] lo_q, hi_q, lo_n, hi_n;
  logic                          any_q, any_n;
  logic [NA-1:0][COORD_BITS-1:0] min_d, max_d, box_min_q, box_max_q;
  logic                          out_valid_q, found_q;
  logic [COORD_BITS-1:0]         pad_ext;
  logic [COORD_BITS:0]           hi_pad;

  // Drop the final voxel only when the result register can take the box
  assign pop_o = q_valid_i && (!last_i || !out_valid_q || out_ready_i);

  assign pad_ext = COORD_BITS'(pad_i);
  assign any_n   = any_q || fg_i;

  always_comb begin
    hi_pad = '0;
    for (int a = 0; a < NA; a++) begin
      lo_n[a] = (fg_i && (pos_i[a] < lo_q[a])) ? pos_i[a] : lo_q[a];
      hi_n[a] = (fg_i && (pos_i[a] > hi_q[a])) ? pos_i[a] : hi_q[a];
    end
    for (int a = 0; a < NA; a++) begin
      hi_pad = {1'b0, hi_n[a]} + (COORD_BITS + 1)'(pad_i);
      if (any_n) begin
        min_d[a] = (lo_n[a] > pad_ext) ? (lo_n[a] - pad_ext) : '0;
        max_d[a] = (hi_pad > {1'b0, axis_last_i[a]}) ? axis_last_i[a]
                                                     : hi_pad[COORD_BITS-1:0];
      end else begin
        min_d[a] = '0;
        max_d[a] = axis_last_i[a];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lo_q        <= '1;
      hi_q        <= '0;
      any_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (pop_o) begin
        if (last_i) begin
          lo_q        <= '1;
          hi_q        <= '0;
          any_q       <= 1'b0;
          out_valid_q <= 1'b1;
        end else begin
          lo_q  <= lo_n;
          hi_q  <= hi_n;
          any_q <= any_n;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && last_i) begin
      found_q   <= any_n;
      box_min_q <= min_d;
      box_max_q <= max_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign found_o     = found_q;
  assign box_min_o   = box_min_q;
  assign box_max_o   = box_max_q;

endmodule : fbb_back

`default_nettype wire

// ----- rtl/foreground_bounding_box.sv -----
// ----------------------------------------------------------------------------
// foreground_bounding_box: 3D foreground bounding box over a voxel stream
// Track the extent of voxels whose magnitude exceeds a threshold and report
// the padded, clamped box once per volume.
// ----------------------------------------------------------------------------
// Usage:
//   smp_i carries one voxel per item in raster order, x fastest, then y, z.
//   res_o carries one item per volume: the found flag and the box corners.
//   cfg_we_i/cfg_index_i/cfg_wdata_i write the size, pad and threshold
//   registers; write them only while no volume is in flight.
// Throughput: one voxel per cycle while no pending result stalls the back;
//   the front classifier and back tracker each do constant work per item.
// Result path: the last voxel of the volume passes through the queue and is
//   folded into the result register that drives res_o; a pending result can
//   hold it in the queue first.
// Reset: registers take their default values (1024^3 volume, pad 2,
//   threshold 0), counters and trackers clear, the queue empties.
// Stall: a pending result holds in its register while voxels keep flowing;
//   the back stops only at the next volume's last voxel, the two-entry queue
//   then fills and smp_i.ready drops until res_o is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module foreground_bounding_box #(
  parameter int COORD_BITS  = fbb_pkg::COORD_BITS_DEF,
  parameter int SAMPLE_BITS = fbb_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  fbb_smp_if.sink                              smp_i,
  fbb_res_if.source                            res_o,
  input  wire logic                            cfg_we_i,
  input  wire logic [fbb_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [fbb_pkg::CFG_DATA_W-1:0]  cfg_wdata_i
);

  localparam int NA = fbb_pkg::NUM_AXES;
  localparam int SW = fbb_pkg::CFG_SIZE_W;
  // Wide enough to hold both the size register and 2^COORD_BITS
  localparam int WB = (SW > COORD_BITS + 1) ? SW : COORD_BITS + 1;
  localparam logic [WB-1:0] CAP = WB'(1) << COORD_BITS;
  localparam int QW = NA * COORD_BITS + 2;

  // Configuration registers
  logic [NA-1:0][SW-1:0]              size_q;
  logic [fbb_pkg::CFG_PAD_W-1:0]      pad_q;
  logic [fbb_pkg::CFG_THR_W-1:0]      thresh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q   <= {NA{fbb_pkg::SIZE_RST}};
      pad_q    <= fbb_pkg::PAD_RST;
      thresh_q <= fbb_pkg::THRESH_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        fbb_pkg::REG_SIZE_X: size_q[fbb_pkg::AXIS_X] <= cfg_wdata_i[SW-1:0];
        fbb_pkg::REG_SIZE_Y: size_q[fbb_pkg::AXIS_Y] <= cfg_wdata_i[SW-1:0];
        fbb_pkg::REG_SIZE_Z: size_q[fbb_pkg::AXIS_Z] <= cfg_wdata_i[SW-1:0];
        fbb_pkg::REG_PAD:    pad_q    <= cfg_wdata_i[fbb_pkg::CFG_PAD_W-1:0];
        fbb_pkg::REG_THRESH: thresh_q <= cfg_wdata_i[fbb_pkg::CFG_THR_W-1:0];
        default: ;  // unmapped index: drop the write
      endcase
    end
  end

  // Last coordinate per axis: a size of zero acts as one, and a size beyond
  // the coordinate range saturates at the full range
  logic [NA-1:0][COORD_BITS-1:0] axis_last;
  logic [WB-1:0]                 size_ext;

  always_comb begin
    size_ext = '0;
    for (int a = 0; a < NA; a++) begin
      size_ext = WB'(size_q[a]);
      if (size_ext == '0) begin
        axis_last[a] = '0;
      end else if (size_ext > CAP) begin
        axis_last[a] = COORD_BITS'(CAP - WB'(1));
      end else begin
        axis_last[a] = COORD_BITS'(size_ext - WB'(1));
      end
    end
  end

  // Front: classify and tag each voxel
  logic                          q_push, q_full, q_pop, q_valid;
  logic [NA-1:0][COORD_BITS-1:0] f_pos, b_pos;
  logic                          f_fg, f_last, b_fg, b_last;
  logic [QW-1:0]                 q_wdata, q_rdata;

  fbb_front #(
    .COORD_BITS  (COORD_BITS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (smp_i.valid),
    .sample_i (smp_i.sample),
    .ready_o  (smp_i.ready),
    .thresh_i (thresh_q),
    .last_i   (axis_last),
    .q_full_i (q_full),
    .push_o   (q_push),
    .pos_o    (f_pos),
    .fg_o     (f_fg),
    .last_o   (f_last)
  );

  assign q_wdata = {f_fg, f_last, f_pos};

  // Queue: decouple the classifier from the tracker
  fbb_fifo #(
    .WIDTH (QW),
    .DEPTH (2)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .wdata_i (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .rdata_o (q_rdata),
    .valid_o (q_valid)
  );

  assign b_fg   = q_rdata[QW-1];
  assign b_last = q_rdata[QW-2];
  assign b_pos  = q_rdata[QW-3:0];

  // Back: fold positions into the box and hold the result
  logic [NA-1:0][COORD_BITS-1:0] box_min, box_max;

  fbb_back #(
    .COORD_BITS (COORD_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .pos_i       (b_pos),
    .fg_i        (b_fg),
    .last_i      (b_last),
    .pop_o       (q_pop),
    .pad_i       (pad_q),
    .axis_last_i (axis_last),
    .out_valid_o (res_o.valid),
    .out_ready_i (res_o.ready),
    .found_o     (res_o.found),
    .box_min_o   (box_min),
    .box_max_o   (box_max)
  );

  assign res_o.box_min_x = box_min[fbb_pkg::AXIS_X];
  assign res_o.box_max_x = box_max[fbb_pkg::AXIS_X];
  assign res_o.box_min_y = box_min[fbb_pkg::AXIS_Y];
  assign res_o.box_max_y = box_max[fbb_pkg::AXIS_Y];
  assign res_o.box_min_z = box_min[fbb_pkg::AXIS_Z];
  assign res_o.box_max_z = box_max[fbb_pkg::AXIS_Z];

  // Assertions
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !q_full)
    else $error("queue written while full");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_valid)
    else $error("queue read while empty");

  a_result_from_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_o.valid) |-> $past(q_pop && b_last))
    else $error("result raised without a final voxel");

  a_last_holds_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_valid && b_last && res_o.valid && !res_o.ready) |-> !q_pop)
    else $error("final voxel dropped over a pending result");

endmodule : foreground_bounding_box

`default_nettype wire

// ----- test/fbb_box_checker.sv -----
// ----------------------------------------------------------------------------
// fbb_box_checker: box predictor and result scoreboard
// Snoop register writes and accepted voxels, keep a private copy of the
// position counters and the extent trackers, and compare every box item on
// the result channel with the oldest predicted box.
// ----------------------------------------------------------------------------
`default_nettype none

module fbb_box_checker
  import fbb_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  fbb_smp_if                         smp_i,
  fbb_res_if                         res_i,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i,
  output int                         mismatches_o,
  output int                         pending_o,
  output int                         boxes_o,
  output int                         found_o
);

  localparam int CB = COORD_BITS_DEF;
  localparam int SB = SAMPLE_BITS_DEF;

  typedef logic [CB-1:0] coord_t;

  typedef struct packed {
    logic   found;
    coord_t min_x;
    coord_t max_x;
    coord_t min_y;
    coord_t max_y;
    coord_t min_z;
    coord_t max_z;
  } box_t;

  logic [CFG_SIZE_W-1:0] size_q [NUM_AXES];
  logic [CFG_PAD_W-1:0]  pad_q;
  logic [CFG_THR_W-1:0]  thresh_q;

  coord_t pos [NUM_AXES];
  coord_t lo  [NUM_AXES];
  coord_t hi  [NUM_AXES];
  logic   seen;

  box_t expected_boxes [$];
  int   mismatch_count;
  int   box_count;
  int   found_count;

  // Last usable coordinate of an axis: zero acts as one, oversize saturates.
  function automatic coord_t axis_last(input logic [CFG_SIZE_W-1:0] size);
    if (size == '0) return '0;
    if (size > (CFG_SIZE_W'(1) << CB)) return '1;
    return coord_t'(size - 1'b1);
  endfunction

  task automatic clear_tracking();
    for (int a = 0; a < NUM_AXES; a++) begin
      pos[a] = '0;
      lo[a]  = '1;
      hi[a]  = '0;
    end
    seen = 1'b0;
  endtask

  task automatic check_field(input string field, input coord_t want, input coord_t got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      mismatch_count++;
    end
  endtask

  // Track one voxel; on the last voxel of the volume queue its box.
  task automatic take_voxel(input logic signed [SB-1:0] value);
    logic [SB:0]   mag;
    coord_t        last   [NUM_AXES];
    logic          at_end [NUM_AXES];
    coord_t        bmin   [NUM_AXES];
    coord_t        bmax   [NUM_AXES];
    logic [CB:0]   reach;
    box_t          box;
    mag = value[SB-1] ? (~{1'b1, value} + 1'b1) : {1'b0, value};
    for (int a = 0; a < NUM_AXES; a++) begin
      last[a]   = axis_last(size_q[a]);
      at_end[a] = pos[a] >= last[a];
    end
    if (mag > {{(SB+1-CFG_THR_W){1'b0}}, thresh_q}) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        if (pos[a] < lo[a]) lo[a] = pos[a];
        if (pos[a] > hi[a]) hi[a] = pos[a];
      end
      seen = 1'b1;
    end
    if (at_end[AXIS_X] && at_end[AXIS_Y] && at_end[AXIS_Z]) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        if (!seen) begin
          bmin[a] = '0;
          bmax[a] = last[a];
        end else begin
          bmin[a] = (lo[a] > coord_t'(pad_q)) ? lo[a] - coord_t'(pad_q) : '0;
          reach   = {1'b0, hi[a]} + pad_q;
          bmax[a] = (reach > {1'b0, last[a]}) ? last[a] : reach[CB-1:0];
        end
      end
      box.found = seen;
      box.min_x = bmin[AXIS_X];
      box.max_x = bmax[AXIS_X];
      box.min_y = bmin[AXIS_Y];
      box.max_y = bmax[AXIS_Y];
      box.min_z = bmin[AXIS_Z];
      box.max_z = bmax[AXIS_Z];
      expected_boxes = {expected_boxes, box};
      clear_tracking();
    end else if (!at_end[AXIS_X]) begin
      pos[AXIS_X] = pos[AXIS_X] + 1'b1;
    end else begin
      pos[AXIS_X] = '0;
      if (!at_end[AXIS_Y]) begin
        pos[AXIS_Y] = pos[AXIS_Y] + 1'b1;
      end else begin
        pos[AXIS_Y] = '0;
        pos[AXIS_Z] = pos[AXIS_Z] + 1'b1;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q[AXIS_X] = SIZE_RST;
      size_q[AXIS_Y] = SIZE_RST;
      size_q[AXIS_Z] = SIZE_RST;
      pad_q          = PAD_RST;
      thresh_q       = THRESH_RST;
      clear_tracking();
      expected_boxes.delete();
      mismatch_count = 0;
      box_count      = 0;
      found_count    = 0;
      mismatches_o <= 0;
      pending_o    <= 0;
      boxes_o      <= 0;
      found_o      <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_SIZE_X: size_q[AXIS_X] = cfg_wdata_i[CFG_SIZE_W-1:0];
          REG_SIZE_Y: size_q[AXIS_Y] = cfg_wdata_i[CFG_SIZE_W-1:0];
          REG_SIZE_Z: size_q[AXIS_Z] = cfg_wdata_i[CFG_SIZE_W-1:0];
          REG_PAD:    pad_q          = cfg_wdata_i[CFG_PAD_W-1:0];
          REG_THRESH: thresh_q       = cfg_wdata_i[CFG_THR_W-1:0];
          default: ;
        endcase
      end
      // Compare before predicting so a stray result is never masked.
      if (res_i.valid && res_i.ready) begin
        if (expected_boxes.size() == 0) begin
          $error("result item with no box expected");
          mismatch_count++;
        end else begin
          box_t want;
          want = expected_boxes.pop_front();
          check_field("found",     coord_t'(want.found), coord_t'(res_i.found));
          check_field("box_min_x", want.min_x, res_i.box_min_x);
          check_field("box_max_x", want.max_x, res_i.box_max_x);
          check_field("box_min_y", want.min_y, res_i.box_min_y);
          check_field("box_max_y", want.max_y, res_i.box_max_y);
          check_field("box_min_z", want.min_z, res_i.box_min_z);
          check_field("box_max_z", want.max_z, res_i.box_max_z);
          box_count++;
          if (want.found) found_count++;
        end
      end
      if (smp_i.valid && smp_i.ready) take_voxel(smp_i.sample);
      mismatches_o <= mismatch_count;
      pending_o    <= expected_boxes.size();
      boxes_o      <= box_count;
      found_o      <= found_count;
    end
  end

endmodule : fbb_box_checker

`default_nettype wire

// ----- test/foreground_bounding_box_test.sv -----
// ----------------------------------------------------------------------------
// foreground_bounding_box_test: stimulus and verdict for the bounding box
// Stream voxel volumes of many shapes, thresholds and margins through the
// block under random backpressure and gaps; a side-by-side checker predicts
// each padded box and reports mismatches, this module gives the verdict.
// ----------------------------------------------------------------------------
`default_nettype none

module foreground_bounding_box_test;
  import fbb_pkg::*;

  localparam int CB            = COORD_BITS_DEF;
  localparam int SB            = SAMPLE_BITS_DEF;
  localparam int CLK_PERIOD    = 20;
  localparam int RESET_CYCLES  = 6;
  localparam int SETTLE_CYCLES = 8;       // extra wait after the last predicted box is taken
  localparam int IDLE_PERCENT  = 23;
  localparam int RANDOM_ITEMS  = 800;
  localparam int HOLD_CYCLES   = 300;
  localparam int RUN_LIMIT     = 8_000_000;
  localparam int SPARE_SIZE_W  = CFG_DATA_W - CFG_SIZE_W;
  localparam int SPARE_PAD_W   = CFG_DATA_W - CFG_PAD_W;
  localparam int MAX_MAG       = 32768;

  // Index 5 has no register behind it; writes there must be dropped.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd5;

  localparam logic signed [SB-1:0] SAMPLE_MIN = {1'b1, {(SB-1){1'b0}}};
  localparam logic signed [SB-1:0] SAMPLE_MAX = {1'b0, {(SB-1){1'b1}}};
  localparam logic [CFG_THR_W-1:0] THRESH_MAX = '1;
  localparam logic [CFG_PAD_W-1:0] PAD_MAX    = '1;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  fbb_smp_if smp ();
  fbb_res_if res ();

  int mismatches;
  int boxes_pending;
  int boxes_seen;
  int boxes_found;

  // Shared between the sender and the receiver process.
  bit                   calm;           // no idling on either side
  int                   hold_requests;  // bump to start one long output hold-off
  int                   voxels_sent;
  int                   volume_len;
  int                   phases;
  logic [CFG_THR_W-1:0] thr_now;

  foreground_bounding_box dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .smp_i       (smp),
    .res_o       (res),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_wdata_i (cfg_wdata)
  );

  fbb_box_checker box_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .smp_i        (smp),
    .res_i        (res),
    .cfg_we_i     (cfg_we),
    .cfg_index_i  (cfg_index),
    .cfg_wdata_i  (cfg_wdata),
    .mismatches_o (mismatches),
    .pending_o    (boxes_pending),
    .boxes_o      (boxes_seen),
    .found_o      (boxes_found)
  );

  initial begin
    clk_i = 1'b0;
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  // Give up if the run hangs on a handshake or a missing box.
  initial begin
    #(RUN_LIMIT);
    $display("foreground_bounding_box_test: FAIL");
    $finish;
  end

  // Result side: random backpressure, a calm mode that always takes the box,
  // and a long hold-off on request so the queue fills and the input stalls.
  initial begin
    int hold_left;
    int holds_served;
    hold_left    = 0;
    holds_served = 0;
    res.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (holds_served != hold_requests) begin
        holds_served = hold_requests;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        res.ready <= 1'b0;
        hold_left--;
      end else if (calm) begin
        res.ready <= 1'b1;
      end else begin
        res.ready <= ($urandom_range(0, 99) >= IDLE_PERCENT);
      end
    end
  end

  // Voxel count along one axis for a size register value.
  function automatic int axis_len(input logic [CFG_SIZE_W-1:0] size);
    if (size == '0) return 1;
    if (size > (CFG_SIZE_W'(1) << CB)) return 1 << CB;
    return int'(size);
  endfunction

  // Pick a voxel: mostly background at or under the threshold, fg_percent of
  // foreground just above it up to the full magnitude, and a few raw patterns.
  function automatic logic signed [SB-1:0] pick_sample(input int fg_percent);
    int                  roll;
    int unsigned         mag;
    logic signed [SB-1:0] value;
    roll = $urandom_range(0, 99);
    if (roll < 5) return SB'($urandom);
    if (roll < 5 + fg_percent) mag = $urandom_range(MAX_MAG, thr_now + 1);
    else mag = $urandom_range(thr_now, 0);
    value = SB'(mag);
    if ($urandom_range(0, 1)) value = -value;
    return value;
  endfunction

  // Offer one voxel, with a random gap first unless calm; hold until taken.
  task automatic send_voxel(input logic signed [SB-1:0] value);
    if (!calm && $urandom_range(0, 99) < IDLE_PERCENT) begin
      smp.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    smp.valid  <= 1'b1;
    smp.sample <= value;
    @(posedge clk_i);
    while (!smp.ready) @(posedge clk_i);
    voxels_sent++;
  endtask

  task automatic send_volume(input int fg_percent);
    repeat (volume_len) send_voxel(pick_sample(fg_percent));
  endtask

  // Drop valid, wait for every predicted box, then let the pipeline empty.
  task automatic settle();
    smp.valid <= 1'b0;
    @(posedge clk_i);
    while (boxes_pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_wdata <= data;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    @(posedge clk_i);
  endtask

  // Program the volume shape; unused upper data bits carry noise.
  task automatic set_volume(input logic [CFG_SIZE_W-1:0] sx, input logic [CFG_SIZE_W-1:0] sy,
                            input logic [CFG_SIZE_W-1:0] sz);
    write_reg(REG_SIZE_X, {SPARE_SIZE_W'($urandom), sx});
    write_reg(REG_SIZE_Y, {SPARE_SIZE_W'($urandom), sy});
    write_reg(REG_SIZE_Z, {SPARE_SIZE_W'($urandom), sz});
    volume_len = axis_len(sx) * axis_len(sy) * axis_len(sz);
  endtask

  task automatic set_rule(input logic [CFG_PAD_W-1:0] pad, input logic [CFG_THR_W-1:0] thr);
    write_reg(REG_PAD, {SPARE_PAD_W'($urandom), pad});
    write_reg(REG_THRESH, thr);
    thr_now = thr;
  endtask

  function automatic logic [CFG_PAD_W-1:0] pick_pad();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return PAD_MAX;
      default: return CFG_PAD_W'($urandom);
    endcase
  endfunction

  function automatic logic [CFG_THR_W-1:0] pick_thresh();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return THRESH_MAX;
      2:       return CFG_THR_W'($urandom);
      default: return CFG_THR_W'($urandom_range(0, 300));
    endcase
  endfunction

  initial begin
    int                    random_base;
    int                    volumes;
    int                    big_axis;
    logic [CFG_SIZE_W-1:0] big;
    logic [CFG_SIZE_W-1:0] shape [NUM_AXES];

    // Drive every input to a known value before the first edge.
    rst_ni     <= 1'b0;
    smp.valid  <= 1'b0;
    smp.sample <= '0;
    cfg_we     <= 1'b0;
    cfg_index  <= '0;
    cfg_wdata  <= '0;
    calm          = 1'b0;
    hold_requests = 0;
    voxels_sent   = 0;
    phases        = 0;
    thr_now       = THRESH_RST;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Single-voxel volumes on the reset margin and threshold: zero is not
    // foreground at threshold zero, minus one and the most negative are.
    set_volume(CFG_SIZE_W'(1), CFG_SIZE_W'(1), CFG_SIZE_W'(1));
    send_voxel('0);
    send_voxel(SB'(-1));
    send_voxel(SAMPLE_MIN);
    settle();

    // Drop a write to the unmapped index; zero sizes act as one.
    write_reg(REG_SPARE, '1);
    set_volume('0, '0, '0);
    send_voxel(SAMPLE_MAX);
    settle();

    // Top threshold: only the most negative sample counts, at (1,1,1).
    set_volume(CFG_SIZE_W'(3), CFG_SIZE_W'(2), CFG_SIZE_W'(2));
    set_rule('0, THRESH_MAX);
    for (int i = 0; i < 12; i++) begin
      send_voxel(i == 10 ? SAMPLE_MIN : (i[0] ? SAMPLE_MAX : -SAMPLE_MAX));
    end
    settle();

    // Shrink x mid-volume: the counter past the new end wraps at once,
    // and the widest margin clamps to the volume.
    set_volume(CFG_SIZE_W'(4), CFG_SIZE_W'(1), CFG_SIZE_W'(1));
    set_rule(PAD_MAX, CFG_THR_W'(10));
    send_voxel(SB'(50));
    send_voxel('0);
    send_voxel(SB'(-10));
    settle();
    write_reg(REG_SIZE_X, CFG_DATA_W'(2));
    send_voxel('0);
    settle();

    // Hold the result side for a long stretch while tiny volumes keep
    // coming: the box register and queue fill and the input must stall.
    set_volume(CFG_SIZE_W'(2), CFG_SIZE_W'(1), CFG_SIZE_W'(1));
    set_rule(pick_pad(), '0);
    hold_requests++;
    repeat (30) send_volume(40);
    settle();
    phases = 5;

    // One full-length axis, written above the cap or exactly at it.
    big_axis = $urandom_range(0, NUM_AXES - 1);
    big = ($urandom_range(0, 3) == 0) ? (CFG_SIZE_W'(1) << CB)
                                      : CFG_SIZE_W'($urandom_range(1024, 2047));
    for (int b = 0; b < NUM_AXES; b++) begin
      shape[b] = (b == big_axis) ? big : CFG_SIZE_W'($urandom_range(0, 1));
    end
    set_volume(shape[AXIS_X], shape[AXIS_Y], shape[AXIS_Z]);
    set_rule(pick_pad(), pick_thresh());
    send_volume(2);
    settle();
    phases++;

    // Random phases: new shape and rule each time, a few volumes each,
    // with one calm stretch where neither side idles.
    random_base = voxels_sent;
    while (voxels_sent - random_base < RANDOM_ITEMS) begin
      calm = (voxels_sent - random_base >= 300) && (voxels_sent - random_base < 550);
      set_volume(CFG_SIZE_W'($urandom_range(0, 7)), CFG_SIZE_W'($urandom_range(0, 5)),
                 CFG_SIZE_W'($urandom_range(0, 3)));
      set_rule(pick_pad(), pick_thresh());
      if ($urandom_range(0, 9) == 0) write_reg(REG_SPARE, CFG_DATA_W'($urandom));
      volumes = $urandom_range(1, 4);
      repeat (volumes) send_volume($urandom_range(0, 4) == 0 ? 0 : $urandom_range(1, 30));
      settle();
      phases++;
    end
    calm = 1'b0;

    // Every box is in and the pipeline has emptied: give the verdict.
    settle();
    $display("Covered %0d voxels over %0d register phases: %0d boxes, %0d with foreground.",
             voxels_sent, phases, boxes_seen, boxes_found);
    $display("Shapes ran from one voxel to a full-length axis, with a long output hold-off.");
    if (mismatches == 0) begin
      $display("foreground_bounding_box_test: PASS");
    end else begin
      $display("foreground_bounding_box_test: FAIL");
    end
    $finish;
  end

endmodule : foreground_bounding_box_test

`default_nettype wire

// ----- sim.f -----
rtl/fbb_pkg.sv
rtl/fbb_if.sv
rtl/fbb_front.sv
rtl/fbb_fifo.sv
rtl/fbb_back.sv
rtl/foreground_bounding_box.sv
test/fbb_box_checker.sv
test/foreground_bounding_box_test.sv
